/* rtl/core/rmtf_pkg.sv */
// shared constants and types of the rank move-to-front list
package rmtf_pkg;

  localparam int LIST_SIZE  = 256;
  localparam int IDX_W      = $clog2(LIST_SIZE);
  localparam int SYM_W      = 9;
  localparam int LEN_W      = 9;
  localparam int RANK_W     = 9;
  localparam int GROUPS     = 16;
  localparam int GROUP_SIZE = LIST_SIZE / GROUPS;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  // register index, taken from the word address
  localparam logic REG_LIST_LENGTH = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0] lookup_idx;
    logic             update_en;
    logic [IDX_W-1:0] move_idx;
    logic [SYM_W-1:0] front_sym;
  } cell_ctrl_t;

endpackage

/* rtl/core/rank_move_to_front_list.sv */
// top level of the rank move-to-front list
// Move-to-front decoder over a list of 256 symbols held in a row of cells,
// one entry per cell, starting as 1..256 front to back after reset. Each
// rank transfer looks up the symbol at that 1-based rank, returns it and
// moves it to the front while every cell ahead of it takes its front
// neighbor's entry. A rank of zero or above min(list_length, 256) returns
// symbol zero with rank_invalid set and leaves the list as it was. The
// transfer cycle decodes the rank in every cell and registers sixteen
// partial selections; the finishing step then merges them, shifts the
// chain and loads the output register. A new rank is taken the cycle
// after the result is loaded, so the block does not take a new rank before
// it is through with the last one; a stalled output holds the result and
// the block waits for it. list_length sits at byte address 0 of the APB
// port and may be written only while the block is idle.
module rank_move_to_front_list import rmtf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // rank input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RANK_W-1:0]     rank_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SYM_W-1:0]      symbol_o,
  output logic                  rank_invalid_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_FINISH = 2'b10
  } state_e;

  state_e state_d, state_q;

  logic [LEN_W-1:0] list_length_q;
  logic [LEN_W-1:0] eff_len;
  logic             cfg_write;

  logic             in_xfer;
  logic             rank_ok;
  logic             rank_ok_q;
  logic [IDX_W-1:0] rank_idx;
  logic [IDX_W-1:0] move_idx_q;
  logic             finish_fire;

  logic [SYM_W-1:0] entries [LIST_SIZE];
  logic [SYM_W-1:0] picks   [LIST_SIZE];
  logic [SYM_W-1:0] grp_d   [GROUPS];
  logic [SYM_W-1:0] grp_q   [GROUPS];
  logic [SYM_W-1:0] found;

  logic             out_valid_q;
  logic [SYM_W-1:0] symbol_q;
  logic             invalid_q;

  cell_ctrl_t       cell_ctrl;

  // apb register: list_length
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LIST_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_length_q <= LEN_RESET;
    end else if (cfg_write) begin
      list_length_q <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LIST_LENGTH) begin
      prdata = APB_DATA_W'(list_length_q);
    end
  end

  // rank check against the length actually in use
  assign eff_len  = (list_length_q < LEN_W'(LIST_SIZE)) ? list_length_q : LEN_W'(LIST_SIZE);
  assign rank_ok  = (rank_i != '0) && (LEN_W'(rank_i) <= eff_len);
  assign rank_idx = IDX_W'(rank_i - RANK_W'(1));

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // finishing step waits for a free output register
  assign finish_fire = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    found = '0;
    for (int g = 0; g < GROUPS; g++) begin
      found = found | grp_q[g];
    end
  end

  always_comb begin
    cell_ctrl.lookup_idx = rank_idx;
    cell_ctrl.update_en  = finish_fire && rank_ok_q;
    cell_ctrl.move_idx   = move_idx_q;
    cell_ctrl.front_sym  = found;
  end

  // chain of cells, each fed by its front neighbor
  for (genvar c = 0; c < LIST_SIZE; c++) begin : g_cell
    logic [SYM_W-1:0] prev_entry;
    if (c == 0) begin : g_front
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_entry = entries[c-1];
    end
    rmtf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .pos_i        (IDX_W'(c)),
      .ctrl_i       (cell_ctrl),
      .prev_entry_i (prev_entry),
      .entry_o      (entries[c]),
      .pick_o       (picks[c])
    );
  end

  // first level of the select tree: one or per group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_d[g] = grp_d[g] | picks[g*GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      grp_q      <= grp_d;
      rank_ok_q  <= rank_ok;
      move_idx_q <= rank_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      symbol_q  <= rank_ok_q ? found : '0;
      invalid_q <= !rank_ok_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign rank_invalid_o = invalid_q;

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("rank taken while an item is in flight");

  // the list moves only together with a new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.update_en |=> out_valid_o && !rank_invalid_o)
    else $error("list shifted without a valid result");

  // a rejected rank never reports a symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rank_invalid_o) |-> (symbol_o == '0))
    else $error("invalid rank with nonzero symbol");

  // the front entry after a move is the symbol just returned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.update_en |=> (entries[0] == symbol_o))
    else $error("front entry differs from returned symbol");

endmodule

/* rtl/core/rmtf_cell.sv */
// one list entry of the move-to-front chain
module rmtf_cell import rmtf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] pos_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [SYM_W-1:0] prev_entry_i,
  output logic [SYM_W-1:0] entry_o,
  output logic [SYM_W-1:0] pick_o
);

  logic [SYM_W-1:0] init_val;
  logic [SYM_W-1:0] delta_d, delta_q;
  logic [SYM_W-1:0] new_entry;

  // entry kept as xor against its reset symbol, so reset clears to zero
  assign init_val = SYM_W'(pos_i) + SYM_W'(1);
  assign entry_o  = delta_q ^ init_val;
  assign pick_o   = (pos_i == ctrl_i.lookup_idx) ? entry_o : '0;

  always_comb begin
    new_entry = (pos_i == '0) ? ctrl_i.front_sym : prev_entry_i;
    delta_d   = delta_q;
    if (ctrl_i.update_en && (pos_i <= ctrl_i.move_idx)) begin
      delta_d = new_entry ^ init_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
    end else begin
      delta_q <= delta_d;
    end
  end

endmodule
